[hw/rtl/smx_pkg.sv]
package smx_pkg;
    localparam int MaxLenDefault = 64;
    localparam int LutEntriesDefault = 256;
    localparam int ScoreW = 32;
    localparam int ProbW = 17;
    localparam int PosW = 6;
    localparam int SumW = 23;
    localparam int ExpW = 17;
    // entries past this index are all zero in Q1.16
    localparam int ExpTabLen = 256;

    typedef logic [ExpTabLen-1:0][ExpW-1:0] exp_tab_t;

    // exp(-i/16) in Q1.16, rounded to nearest; series and powers kept with 62 fraction bits
    function automatic exp_tab_t exp_table();
        logic [63:0]  term, base, v;
        logic [127:0] prod;
        exp_tab_t     t;
        begin
            term = 64'd1 << 62;
            base = 64'd1 << 62;
            for (int n = 1; n < 24; n++) begin
                term = (term >> 4) / 64'(n);
                if (n % 2 == 1) base = base - term;
                else base = base + term;
            end
            v = 64'd1 << 62;
            for (int i = 0; i < ExpTabLen; i++) begin
                t[i] = ExpW'((v + (64'd1 << 45)) >> 46);
                prod = {64'd0, v} * {64'd0, base};
                v = prod[125:62];
            end
            exp_table = t;
        end
    endfunction

    typedef struct packed {
        logic [ScoreW-1:0] score;
        logic              final_item;
        logic              overflow;
    } smx_job_t;
endpackage

[hw/rtl/softmax_exp_lut.sv]
// Softmax over vectors of up to MAX_LEN Q15.16 scores. Scores stream in one per
// cycle until tlast while the block is loading; extras past MAX_LEN are dropped
// and flag overflow. Then the block sums table-based exp values and emits one
// probability per element, each from a 33-step serial divider. While a vector
// is processed only one score of the next vector is buffered; the rest wait
// until the last result is taken.
module softmax_exp_lut
    import smx_pkg::*;
#(
    parameter int MAX_LEN     = MaxLenDefault,
    parameter int LUT_ENTRIES = LutEntriesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // score
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // prob[16:0], position[22:17], zero
    output logic        m_tlast,
    output logic        m_tuser    // overflow
);
    logic     jv, jr;
    smx_job_t job, q_job;
    logic     qv_reg, qr;
    smx_job_t q_reg;
    logic [ProbW-1:0] prob;
    logic [PosW-1:0]  pos;

    smx_front #(.MAX_LEN(MAX_LEN)) u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_score(s_tdata), .in_last(s_tlast), .job_valid(jv), .job_ready(jr), .job(job)
    );

    // one-entry queue between front and back
    assign jr = !qv_reg || qr;
    always_ff @(posedge aclk) begin
        if (!aresetn) qv_reg <= 1'b0;
        else if (jr) qv_reg <= jv;
        if (jr && jv) q_reg <= job;
    end
    assign q_job = q_reg;

    smx_back #(.MAX_LEN(MAX_LEN), .LUT_ENTRIES(LUT_ENTRIES)) u_back (
        .aclk(aclk), .aresetn(aresetn), .job_valid(qv_reg), .job_ready(qr), .job(q_job),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_prob(prob), .out_pos(pos),
        .out_final(m_tlast), .out_ovf(m_tuser)
    );
    assign m_tdata = {1'b0, pos, prob};
endmodule

[hw/rtl/smx_div.sv]
module smx_div
    import smx_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [ExpW-1:0]     num,
    input  logic [SumW-1:0]     den,
    output logic                busy,
    output logic                done,
    output logic [ProbW-1:0]    quo
);
    localparam int NW = ExpW + 16;
    logic [NW-1:0]   q_reg, q_next;
    logic [SumW:0]   r_reg, r_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next, done_reg, done_next;
    logic [SumW:0]   trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg[SumW-1:0], q_reg[NW-1]};
        if (start) begin
            q_next = {num, 16'd0};
            r_next = '0;
            cnt_next = 6'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den}) begin
                r_next = trial - {1'b0, den};
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = q_reg[ProbW-1:0];
endmodule

[hw/rtl/smx_front.sv]
module smx_front
    import smx_pkg::*;
#(
    parameter int MAX_LEN = MaxLenDefault
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ScoreW-1:0] in_score,
    input  logic              in_last,
    output logic              job_valid,
    input  logic              job_ready,
    output smx_job_t          job
);
    // Front: counts, flags overflow, forwards kept scores; last item always forwarded.
    logic [PosW:0] cnt_reg;
    logic          drop_reg;
    logic          keep, acc;

    assign keep      = cnt_reg < (PosW+1)'(MAX_LEN);
    assign job_valid = in_valid && (keep || in_last);
    assign in_ready  = job_ready || (!keep && !in_last);
    assign acc       = in_valid && in_ready;

    assign job.score      = in_score;
    assign job.final_item = in_last;
    assign job.overflow   = drop_reg || !keep;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end else if (acc) begin
            if (in_last) begin
                cnt_reg  <= '0;
                drop_reg <= 1'b0;
            end else if (keep) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else begin
                drop_reg <= 1'b1;
            end
        end
    end
endmodule

[hw/rtl/smx_back.sv]
module smx_back
    import smx_pkg::*;
#(
    parameter int MAX_LEN     = MaxLenDefault,
    parameter int LUT_ENTRIES = LutEntriesDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               job_valid,
    output logic               job_ready,
    input  smx_job_t           job,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ProbW-1:0]   out_prob,
    output logic [PosW-1:0]    out_pos,
    output logic               out_final,
    output logic               out_ovf
);
    typedef enum logic [2:0] {LOAD, SUMRD, SUMACC, DVRD, DVSTART, DVWAIT, EMIT} state_t;
    state_t state_reg;

    localparam exp_tab_t ExpTab = exp_table();

    logic [ScoreW-1:0] mem [MAX_LEN];
    logic [ScoreW-1:0] rd_reg;
    logic [PosW:0]     n_reg, i_reg;
    logic [ScoreW-1:0] max_reg;
    logic [SumW-1:0]   sum_reg;
    logic              ovf_reg, wr_last;
    logic [ProbW-1:0]  prob_reg;
    logic              ovalid_reg;
    logic [PosW-1:0]   ri;
    logic [ScoreW:0]   d;
    logic [ExpW-1:0]   e;
    logic              dv_start, dv_busy, dv_done;
    logic [ProbW-1:0]  dv_q;
    logic              wr;

    assign job_ready = (state_reg == LOAD);
    assign wr = job_valid && job_ready && !job.overflow;
    assign ri = i_reg[PosW-1:0];

    always_comb begin
        d = {1'b0, max_reg ^ 32'h80000000} - {1'b0, rd_reg ^ 32'h80000000};
        if (d[ScoreW:12] < (ScoreW-11)'(LUT_ENTRIES) && d[ScoreW:20] == '0)
            e = ExpTab[d[19:12]];
        else
            e = '0;
    end

    assign dv_start = (state_reg == DVSTART);
    smx_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start), .num(e), .den(sum_reg),
        .busy(dv_busy), .done(dv_done), .quo(dv_q)
    );

    always_ff @(posedge aclk) begin
        if (wr) mem[ri] <= job.score;
        rd_reg <= mem[ri];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= LOAD;
            n_reg      <= '0;
            i_reg      <= '0;
            max_reg    <= 32'h80000000;
            sum_reg    <= '0;
            ovf_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            wr_last    <= 1'b0;
        end else begin
            case (state_reg)
                LOAD: if (job_valid) begin
                    if (wr && $signed(job.score) > $signed(max_reg)) max_reg <= job.score;
                    if (job.final_item) begin
                        n_reg   <= wr ? i_reg + 1'b1 : i_reg;
                        ovf_reg <= job.overflow;
                        i_reg   <= '0;
                        sum_reg <= '0;
                        state_reg <= SUMRD;
                    end else if (wr) begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                SUMRD: state_reg <= SUMACC;
                SUMACC: begin
                    sum_reg <= sum_reg + SumW'(e);
                    if (i_reg + 1'b1 == n_reg) begin
                        i_reg <= '0;
                        state_reg <= DVRD;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= SUMRD;
                    end
                end
                DVRD: state_reg <= DVSTART;
                DVSTART: state_reg <= DVWAIT;
                DVWAIT: if (dv_done) begin
                    prob_reg   <= dv_q;
                    ovalid_reg <= 1'b1;
                    wr_last    <= (i_reg + 1'b1 == n_reg);
                    state_reg  <= EMIT;
                end
                EMIT: if (out_ready) begin
                    ovalid_reg <= 1'b0;
                    if (wr_last) begin
                        i_reg   <= '0;
                        max_reg <= 32'h80000000;
                        state_reg <= LOAD;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= DVRD;
                    end
                end
                default: state_reg <= LOAD;
            endcase
        end
    end

    assign out_valid = ovalid_reg;
    assign out_prob  = prob_reg;
    assign out_pos   = ri;
    assign out_final = wr_last;
    assign out_ovf   = ovf_reg;

`ifndef ASSERT_OFF
    a_val: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> state_reg == EMIT) else $error("valid outside emit");
    a_div: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_start |=> dv_busy) else $error("divider not started");
    a_n: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != LOAD |-> n_reg != '0) else $error("empty vector");
`endif
endmodule
